>>> rtl/tbdb_pkg.sv
`default_nettype none

package tbdb_pkg;

    // sizing
    localparam int MAX_COLUMNS = 65536;
    localparam int MAX_SCALE   = 1200;

    localparam int IDX_W   = $clog2(MAX_COLUMNS);
    localparam int CNT_W   = 11;
    localparam int SUM_W   = 21;
    localparam int THR_W   = 16;
    localparam int SCALE_W = 11;
    localparam int COLS_W  = 17;

    // pixel packing: eight pixels per word, rows padded to 32 pixels
    localparam int BYTE_W          = 8;
    localparam int ROW_ALIGN       = 32;
    localparam int BIT_IDX_W       = $clog2(BYTE_W);
    localparam int PHASE_W         = $clog2(ROW_ALIGN);
    localparam int WORDS_PER_ALIGN = ROW_ALIGN / BYTE_W;
    localparam int NWORDS_W        = $clog2(WORDS_PER_ALIGN + 1);
    localparam int BEAT_W          = $clog2(WORDS_PER_ALIGN);

    // output word queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // configuration port
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SCALE     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COLUMNS   = 2'd2;

    // sample state carried into the count update stage
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             hit;
        logic             lbr;
        logic             row_done;
        logic             block_end;
    } cnt_ctl_t;

    // column result handed to the block accumulator
    typedef struct packed {
        logic             valid;
        logic [CNT_W:0]   add;
        logic             lbr;
        logic             row_done;
        logic             block_end;
    } blk_ctl_t;

    // one queued burst of output words: first word, then zero padding
    typedef struct packed {
        logic [BYTE_W-1:0] first;
        logic [BEAT_W-1:0] nwords_m1;
        logic              row_end;
    } desc_t;

    function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] s);
        logic [SCALE_W-1:0] r;
        if (s == '0)
            r = SCALE_W'(1);
        else if (s > SCALE_W'(MAX_SCALE))
            r = SCALE_W'(MAX_SCALE);
        else
            r = s;
        return r;
    endfunction

    function automatic logic [COLS_W-1:0] eff_columns(input logic [COLS_W-1:0] c);
        logic [COLS_W-1:0] r;
        if ((c == '0) || (c > COLS_W'(MAX_COLUMNS)))
            r = COLS_W'(MAX_COLUMNS);
        else
            r = c;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/tbdb_ram.sv
`default_nettype none

module tbdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/tbdb_counts.sv
`default_nettype none

module tbdb_counts (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [tbdb_pkg::THR_W-1:0]   elevation,
    input  wire logic [tbdb_pkg::THR_W-1:0]   threshold,
    input  wire logic [tbdb_pkg::SCALE_W-1:0] scale_eff,
    input  wire logic [tbdb_pkg::COLS_W-1:0]  cols_eff,
    output logic                             clearing,
    output tbdb_pkg::blk_ctl_t               blk
);

    localparam int IDX_W   = tbdb_pkg::IDX_W;
    localparam int CNT_W   = tbdb_pkg::CNT_W;
    localparam int SCALE_W = tbdb_pkg::SCALE_W;
    localparam int COLS_W  = tbdb_pkg::COLS_W;

    logic [IDX_W-1:0]   column_pos_reg, column_pos_next;
    logic [SCALE_W-1:0] band_row_reg, band_row_next;
    logic [SCALE_W-1:0] block_col_reg, block_col_next;

    logic               s1_valid_reg;
    tbdb_pkg::cnt_ctl_t s1_reg, s1_next;

    logic               fwd_valid_reg;
    logic [IDX_W-1:0]   fwd_idx_reg;
    logic [CNT_W-1:0]   fwd_data_reg;

    logic               clear_reg;
    logic [IDX_W-1:0]   clear_addr_reg;

    logic               hit, lbr, row_done, block_end;
    logic [SCALE_W:0]   band_inc, col_inc;
    logic [COLS_W-1:0]  pos_inc;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [CNT_W-1:0]   ram_wdata;
    logic [CNT_W-1:0]   ram_rdata;
    logic [CNT_W-1:0]   cnt;
    logic [CNT_W:0]     add;

    // sample classification and row, band and block position
    always_comb
    begin
        hit       = $signed(elevation) >= $signed(threshold);
        band_inc  = {1'b0, band_row_reg} + (SCALE_W+1)'(1);
        col_inc   = {1'b0, block_col_reg} + (SCALE_W+1)'(1);
        pos_inc   = COLS_W'(column_pos_reg) + COLS_W'(1);
        lbr       = band_inc >= {1'b0, scale_eff};
        row_done  = pos_inc >= cols_eff;
        block_end = lbr && (col_inc >= {1'b0, scale_eff});

        s1_next.idx       = column_pos_reg;
        s1_next.hit       = hit;
        s1_next.lbr       = lbr;
        s1_next.row_done  = row_done;
        s1_next.block_end = block_end;
    end

    always_comb
    begin
        column_pos_next = column_pos_reg;
        band_row_next   = band_row_reg;
        block_col_next  = block_col_reg;
        if (accept)
        begin
            if (lbr)
            begin
                block_col_next = block_end ? '0 : col_inc[SCALE_W-1:0];
            end
            if (row_done)
            begin
                column_pos_next = '0;
                block_col_next  = '0;
                band_row_next   = lbr ? '0 : band_inc[SCALE_W-1:0];
            end
            else
            begin
                column_pos_next = pos_inc[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_pos_reg <= '0;
            band_row_reg   <= '0;
            block_col_reg  <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
        end
        else
        begin
            column_pos_reg <= column_pos_next;
            band_row_reg   <= band_row_next;
            block_col_reg  <= block_col_next;
            s1_valid_reg   <= accept;
            fwd_valid_reg  <= s1_valid_reg;
            // clearing sweep over the whole count memory after reset
            if (clear_reg)
            begin
                clear_addr_reg <= clear_addr_reg + IDX_W'(1);
                if (clear_addr_reg == IDX_W'(tbdb_pkg::MAX_COLUMNS - 1))
                begin
                    clear_reg <= 1'b0;
                end
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_valid_reg)
        begin
            fwd_idx_reg  <= s1_reg.idx;
            fwd_data_reg <= ram_wdata;
        end
    end

    // count update, forwarding the previous write to the same column
    always_comb
    begin
        cnt = (fwd_valid_reg && (fwd_idx_reg == s1_reg.idx)) ? fwd_data_reg : ram_rdata;
        add = {1'b0, cnt} + (CNT_W+1)'(s1_reg.hit);

        if (clear_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clear_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = s1_valid_reg;
            ram_waddr = s1_reg.idx;
            ram_wdata = s1_reg.lbr ? '0 : add[CNT_W-1:0];
        end

        blk.valid     = s1_valid_reg;
        blk.add       = add;
        blk.lbr       = s1_reg.lbr;
        blk.row_done  = s1_reg.row_done;
        blk.block_end = s1_reg.block_end;
    end

    assign clearing = clear_reg;

    tbdb_ram #(
        .WIDTH (CNT_W),
        .DEPTH (tbdb_pkg::MAX_COLUMNS)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (accept),
        .rd_addr (column_pos_reg),
        .rd_data (ram_rdata)
    );

endmodule

`default_nettype wire

>>> rtl/tbdb_pack.sv
`default_nettype none

module tbdb_pack (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tbdb_pkg::blk_ctl_t          blk,
    input  wire logic [tbdb_pkg::SCALE_W-1:0] scale_eff,
    output logic                             push,
    output tbdb_pkg::desc_t                  desc
);

    localparam int SUM_W     = tbdb_pkg::SUM_W;
    localparam int BYTE_W    = tbdb_pkg::BYTE_W;
    localparam int PHASE_W   = tbdb_pkg::PHASE_W;
    localparam int BIT_IDX_W = tbdb_pkg::BIT_IDX_W;
    localparam int NWORDS_W  = tbdb_pkg::NWORDS_W;
    localparam int BEAT_W    = tbdb_pkg::BEAT_W;

    logic [SUM_W-1:0]   block_sum_reg, block_sum_next;
    logic [BYTE_W-1:0]  pack_byte_reg, pack_byte_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;

    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;
    logic               pixel_push, pixel_set, complete, pad;
    logic [BYTE_W-1:0]  pixel_mask, byte_new;
    logic [PHASE_W-1:0] phase_new;
    logic [NWORDS_W-1:0] pad_words, nwords;

    // block accumulation with saturation
    always_comb
    begin
        sum_wide   = {1'b0, block_sum_reg} + (SUM_W+1)'(blk.add);
        sum_sat    = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        pixel_push = blk.valid && blk.lbr && blk.block_end;
        pixel_set  = sum_sat >= SUM_W'(scale_eff);
    end

    // place the pixel, msb first
    always_comb
    begin
        pixel_mask = pixel_set ? (BYTE_W'(1) << (BYTE_W - 1 - int'(phase_reg[BIT_IDX_W-1:0])))
                               : '0;
        byte_new   = pixel_push ? (pack_byte_reg | pixel_mask) : pack_byte_reg;
        phase_new  = phase_reg + PHASE_W'(pixel_push);
        complete   = pixel_push && (phase_reg[BIT_IDX_W-1:0] == BIT_IDX_W'(BYTE_W - 1));
        pad        = blk.valid && blk.row_done && blk.lbr;
        pad_words  = (pad && (phase_new != '0))
                   ? NWORDS_W'(tbdb_pkg::WORDS_PER_ALIGN)
                     - NWORDS_W'(phase_new[PHASE_W-1:BIT_IDX_W])
                   : '0;
        nwords     = NWORDS_W'(complete) + pad_words;

        push           = nwords != '0;
        desc.first     = byte_new;
        desc.nwords_m1 = BEAT_W'(nwords - NWORDS_W'(1));
        desc.row_end   = pad;
    end

    always_comb
    begin
        block_sum_next = block_sum_reg;
        pack_byte_next = pack_byte_reg;
        phase_next     = phase_reg;
        if (blk.valid)
        begin
            if (blk.lbr)
            begin
                block_sum_next = blk.block_end ? '0 : sum_sat;
            end
            if (blk.row_done)
            begin
                block_sum_next = '0;
            end
            // padding closes the row; a full word only restarts the byte
            if (pad)
            begin
                pack_byte_next = '0;
                phase_next     = '0;
            end
            else if (complete)
            begin
                pack_byte_next = '0;
                phase_next     = phase_new;
            end
            else
            begin
                pack_byte_next = byte_new;
                phase_next     = phase_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_sum_reg <= '0;
            pack_byte_reg <= '0;
            phase_reg     <= '0;
        end
        else
        begin
            block_sum_reg <= block_sum_next;
            pack_byte_reg <= pack_byte_next;
            phase_reg     <= phase_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tbdb_outq.sv
`default_nettype none

module tbdb_outq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    input  wire tbdb_pkg::desc_t             desc_in,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [tbdb_pkg::BYTE_W-1:0]      m_tdata,
    output logic                             m_tuser,
    output logic                             m_tlast,
    output logic [tbdb_pkg::QCNT_W-1:0]      q_count
);

    localparam int QDEPTH = tbdb_pkg::QDEPTH;
    localparam int QPTR_W = tbdb_pkg::QPTR_W;
    localparam int QCNT_W = tbdb_pkg::QCNT_W;
    localparam int BEAT_W = tbdb_pkg::BEAT_W;

    tbdb_pkg::desc_t   q_mem [QDEPTH];
    tbdb_pkg::desc_t   head;
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [BEAT_W-1:0] beat_reg, beat_next;
    logic              last_beat, take, pop;

    // head burst expands into its words
    always_comb
    begin
        head      = q_mem[rd_ptr_reg];
        m_tvalid  = count_reg != '0;
        last_beat = beat_reg == head.nwords_m1;
        m_tdata   = (beat_reg == '0) ? head.first : '0;
        m_tlast   = last_beat;
        m_tuser   = last_beat && head.row_end;
        take      = m_tvalid && m_tready;
        pop       = take && last_beat;

        beat_next = beat_reg;
        if (take)
        begin
            beat_next = last_beat ? '0 : beat_reg + BEAT_W'(1);
        end
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            beat_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
            beat_reg  <= beat_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= desc_in;
        end
    end

    assign q_count = count_reg;

endmodule

`default_nettype wire

>>> rtl/threshold_block_downsample_bitpack.sv
// a result word passes the count stage register and then the output queue register before it is offered
// throughput: one sample per cycle while s_tready is high; one word leaves per cycle while m_tready is high;
// a row end adds up to four words; s_tready drops while the four-entry output queue cannot take another burst
// reset: asynchronous, active low; afterwards a clearing pass zeroes all 65536 entries of the
// column count memory, one entry per cycle, with s_tready low; configuration writes still taken
`default_nettype none

module threshold_block_downsample_bitpack (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // slave side, tdata: elevation[15:0]
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [15:0]                  s_tdata,
    // master side, tdata: out_byte[7:0]
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [7:0]                        m_tdata,
    // tuser: row_end[0]
    output logic                              m_tuser,
    output logic                              m_tlast,
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tbdb_pkg::PADDR_W-1:0] paddr,
    input  wire logic [tbdb_pkg::PDATA_W-1:0] pwdata,
    output logic      [tbdb_pkg::PDATA_W-1:0] prdata,
    output logic                              pready
);

    localparam int THR_W   = tbdb_pkg::THR_W;
    localparam int SCALE_W = tbdb_pkg::SCALE_W;
    localparam int COLS_W  = tbdb_pkg::COLS_W;
    localparam int QCNT_W  = tbdb_pkg::QCNT_W;
    localparam int PDATA_W = tbdb_pkg::PDATA_W;

    logic [THR_W-1:0]   threshold_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [COLS_W-1:0]  columns_reg;

    logic [SCALE_W-1:0] scale_eff;
    logic [COLS_W-1:0]  cols_eff;
    logic               cfg_write, accept, clearing, push;
    logic [tbdb_pkg::REG_IDX_W-1:0] reg_idx;
    logic [QCNT_W-1:0]  q_count;
    logic [QCNT_W:0]    credit_used;

    tbdb_pkg::blk_ctl_t blk;
    tbdb_pkg::desc_t    desc;

    // register file
    assign pready    = 1'b1;
    assign reg_idx   = paddr[tbdb_pkg::PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            scale_reg     <= SCALE_W'(1);
            columns_reg   <= COLS_W'(65536);
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                tbdb_pkg::REG_THRESHOLD: threshold_reg <= pwdata[THR_W-1:0];
                tbdb_pkg::REG_SCALE:     scale_reg     <= pwdata[SCALE_W-1:0];
                tbdb_pkg::REG_COLUMNS:   columns_reg   <= pwdata[COLS_W-1:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            tbdb_pkg::REG_THRESHOLD: prdata = PDATA_W'(threshold_reg);
            tbdb_pkg::REG_SCALE:     prdata = PDATA_W'(scale_reg);
            tbdb_pkg::REG_COLUMNS:   prdata = PDATA_W'(columns_reg);
            default:                 prdata = '0;
        endcase
    end

    assign scale_eff = tbdb_pkg::eff_scale(scale_reg);
    assign cols_eff  = tbdb_pkg::eff_columns(columns_reg);

    // accept while the queue holds room for every burst in flight
    assign credit_used = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(blk.valid);
    assign s_tready    = !clearing && (credit_used < (QCNT_W+1)'(tbdb_pkg::QDEPTH));
    assign accept      = s_tvalid && s_tready;

    tbdb_counts u_counts (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .elevation (s_tdata),
        .threshold (threshold_reg),
        .scale_eff (scale_eff),
        .cols_eff  (cols_eff),
        .clearing  (clearing),
        .blk       (blk)
    );

    tbdb_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk       (blk),
        .scale_eff (scale_eff),
        .push      (push),
        .desc      (desc)
    );

    tbdb_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .desc_in  (desc),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .q_count  (q_count)
    );

    // checks
    a_stage_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        blk.valid |-> $past(s_tvalid && s_tready))
        else $error("count stage active without an accepted word");

    a_idle_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (!blk.valid && !push))
        else $error("count memory used during clearing pass");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCNT_W'(tbdb_pkg::QDEPTH))
        else $error("output queue overflow");

    a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("row end flagged on a word that is not the last of its burst");

endmodule

`default_nettype wire
